// ===== rtl/gbp_pkg.sv =====
`timescale 1ns / 1ps
package gbp_pkg;

   localparam int DIM_W  = 9;   // clamped row / column count, up to 127
   localparam int TOT_W  = 17;  // rows * cols, up to 16129
   localparam int DIST_W = 12;
   localparam int CFG_W  = 7;
   localparam int CSR_IDX_W = 4;

   localparam logic [1:0] CELL_WALL   = 2'd1;
   localparam logic [1:0] CELL_PORTAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 4'd1;

   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef enum logic [3:0] {
      S_LOAD, S_CLEAR, S_INIT, S_LEVEL, S_POP, S_POPW, S_DIV, S_NB, S_NBW,
      S_PREAD, S_PIDX, S_PVIS, S_PSELF, S_PSELFW, S_DONE
   } gbp_state_type;

endpackage

// ===== rtl/gbp_div.sv =====
`timescale 1ns / 1ps
module gbp_div
   import gbp_pkg::*;
#(
   parameter int IDX_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IDX_W-1:0] dividend,
   input  logic [DIM_W-1:0] divisor,
   output logic             done,
   output logic [IDX_W-1:0] quot,
   output logic [DIM_W-1:0] rem
);
   localparam int CNT_W = $clog2(IDX_W + 1);

   logic [DIM_W:0]   rem_ff, rem_in, trial;
   logic [IDX_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic             ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial  = {rem_ff[DIM_W-1:0], quo_ff[IDX_W-1]};
      ge     = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? (trial - {1'b0, divisor}) : trial;
         quo_in = {quo_ff << 1} | {{(IDX_W-1){1'b0}}, ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(IDX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff[DIM_W-1:0];

endmodule

// ===== rtl/grid_bfs_with_portals.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  cell_value[1:0], last_cell
// rsp_      out        rsp_valid / rsp_stall  reachable, distance[11:0], portal_overflow
// csr_      in         csr_valid / csr_ready  csr_index[3:0], csr_wdata[6:0]
//
// Loading accepts one cell transaction per cycle. The transaction with last_cell
// starts a search: a clear of rows*cols visited entries (one per cycle), then a
// level-by-level walk; each dequeued cell goes through the divider for its row
// and column, then each direction is checked in turn, and a fresh portal scans
// the stored portals, then the portal cell itself. Memory reads are registered.
// req_stall stays high for the whole search. The result waits in an
// output register; a new search can finish only after it is taken. Reset is
// synchronous, active high.
module grid_bfs_with_portals
   import gbp_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int MAX_PORTALS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cell_value,
   input  logic                 req_last_cell,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_reachable,
   output logic [DIST_W-1:0]    rsp_distance,
   output logic                 rsp_portal_overflow,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);
   localparam int CAP    = MAX_ROWS * MAX_COLS;
   localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CNT_W  = $clog2(CAP + 1);
   localparam int PA_W   = (MAX_PORTALS > 1) ? $clog2(MAX_PORTALS) : 1;
   localparam int PCNT_W = $clog2(MAX_PORTALS + 1);

   // memories
   logic [1:0]       cell_mem   [CAP];
   logic             vis_mem    [CAP];
   logic [IDX_W-1:0] queue_mem  [CAP];
   logic [IDX_W-1:0] portal_mem [MAX_PORTALS];

   gbp_state_type state_ff, state_in;

   logic [CFG_W-1:0]  rows_cfg_ff, cols_cfg_ff;
   logic [DIM_W-1:0]  rows_ff, cols_ff, rows_cl, cols_cl;
   logic [TOT_W-1:0]  total_ff, clr_ff;
   logic [IDX_W-1:0]  target_ff;
   logic [CNT_W-1:0]  load_idx_ff, head_ff, tail_ff, lvl_end_ff;
   logic [PCNT_W-1:0] pcount_ff, pidx_ff;
   logic              ovf_ff;
   logic [DIST_W-1:0] level_ff;
   logic [IDX_W-1:0]  cur_ff, ni_ff, pi_ff;
   logic [DIM_W-1:0]  r_ff, c_ff;
   logic [1:0]        k_ff;
   logic              found_ff;

   logic              rsp_valid_ff;
   logic              rsp_reach_ff, rsp_ovf_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   // memory read data
   logic [1:0]       cell_rd_ff;
   logic             vis_rd_ff;
   logic [IDX_W-1:0] q_rd_ff, portal_rd_ff;

   logic             load_acc;
   logic             nb_ok;
   logic [TOT_W-1:0] ni_wide;
   logic [IDX_W-1:0] ni;
   logic             push_en;
   logic [IDX_W-1:0] push_idx;
   logic             vis_we, vis_wd;
   logic [IDX_W-1:0] vis_wa, vis_ra;
   logic             div_start, div_done;
   logic [IDX_W-1:0] div_quot;
   logic [DIM_W-1:0] div_rem;
   logic             last_dir, rsp_free;

   assign load_acc = req_valid && !req_stall;
   assign last_dir = (k_ff == DIR_LEFT);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // clamp register values into 1..MAX
   always_comb begin
      rows_cl = DIM_W'(rows_cfg_ff);
      if (rows_cfg_ff == '0) rows_cl = DIM_W'(1);
      else if (DIM_W'(rows_cfg_ff) > DIM_W'(MAX_ROWS)) rows_cl = DIM_W'(MAX_ROWS);
      cols_cl = DIM_W'(cols_cfg_ff);
      if (cols_cfg_ff == '0) cols_cl = DIM_W'(1);
      else if (DIM_W'(cols_cfg_ff) > DIM_W'(MAX_COLS)) cols_cl = DIM_W'(MAX_COLS);
   end

   // neighbor of the current cell in direction k
   always_comb begin
      nb_ok   = 1'b0;
      ni_wide = TOT_W'(cur_ff);
      case (k_ff)
         DIR_DOWN: begin
            nb_ok   = (TOT_W'(r_ff) + 1'b1) < TOT_W'(rows_ff);
            ni_wide = TOT_W'(cur_ff) + TOT_W'(cols_ff);
         end
         DIR_RIGHT: begin
            nb_ok   = (TOT_W'(c_ff) + 1'b1) < TOT_W'(cols_ff);
            ni_wide = TOT_W'(cur_ff) + 1'b1;
         end
         DIR_UP: begin
            nb_ok   = r_ff != '0;
            ni_wide = TOT_W'(cur_ff) - TOT_W'(cols_ff);
         end
         DIR_LEFT: begin
            nb_ok   = c_ff != '0;
            ni_wide = TOT_W'(cur_ff) - 1'b1;
         end
         default: ;
      endcase
      ni = ni_wide[IDX_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD:  if (load_acc && req_last_cell) state_in = S_CLEAR;
         S_CLEAR: if (clr_ff == total_ff - 1'b1) state_in = S_INIT;
         S_INIT:  state_in = S_LEVEL;
         S_LEVEL: state_in = (head_ff < tail_ff) ? S_POP : S_DONE;
         S_POP:   state_in = (head_ff == lvl_end_ff) ? S_LEVEL : S_POPW;
         S_POPW:  state_in = (q_rd_ff == target_ff) ? S_DONE : S_DIV;
         S_DIV:   if (div_done) state_in = S_NB;
         S_NB: begin
            if (nb_ok) state_in = S_NBW;
            else if (last_dir) state_in = S_POP;
         end
         S_NBW: begin
            if (cell_rd_ff == CELL_PORTAL && !vis_rd_ff) state_in = S_PREAD;
            else if (last_dir) state_in = S_POP;
            else state_in = S_NB;
         end
         S_PREAD: state_in = (pidx_ff < pcount_ff) ? S_PIDX : S_PSELF;
         S_PIDX: begin
            if (TOT_W'(portal_rd_ff) < total_ff) state_in = S_PVIS;
            else state_in = S_PREAD;
         end
         S_PVIS:   state_in = S_PREAD;
         S_PSELF:  state_in = S_PSELFW;
         S_PSELFW: state_in = last_dir ? S_POP : S_NB;
         S_DONE:   if (rsp_free) state_in = S_LOAD;
         default:  state_in = S_LOAD;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = (state_ff != S_LOAD);
      push_en   = 1'b0;
      push_idx  = ni_ff;
      vis_we    = 1'b0;
      vis_wd    = 1'b1;
      vis_wa    = ni_ff;
      vis_ra    = ni;
      div_start = (state_ff == S_POPW) && (q_rd_ff != target_ff);
      case (state_ff)
         S_CLEAR: begin
            vis_we = 1'b1;
            vis_wd = 1'b0;
            vis_wa = clr_ff[IDX_W-1:0];
         end
         S_INIT: begin
            vis_we = 1'b1;
            vis_wa = '0;
         end
         S_NBW: push_en = (cell_rd_ff != CELL_WALL) && (cell_rd_ff != CELL_PORTAL)
                          && !vis_rd_ff;
         S_PIDX:   vis_ra = portal_rd_ff;
         S_PVIS: begin
            push_en  = !vis_rd_ff;
            push_idx = pi_ff;
         end
         S_PSELF:  vis_ra = ni_ff;
         S_PSELFW: push_en = !vis_rd_ff;
         default: ;
      endcase
      if (push_en) begin
         vis_we = 1'b1;
         vis_wa = push_idx;
      end
   end

   gbp_div #(.IDX_W(IDX_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_rd_ff),
      .divisor  (cols_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (load_acc && load_idx_ff < CNT_W'(CAP))
         cell_mem[load_idx_ff[IDX_W-1:0]] <= req_cell_value;
      cell_rd_ff <= cell_mem[ni];
   end

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_rd_ff <= vis_mem[vis_ra];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_INIT) queue_mem[0] <= '0;
      else if (push_en) queue_mem[tail_ff[IDX_W-1:0]] <= push_idx;
      q_rd_ff <= queue_mem[head_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load_acc && load_idx_ff < CNT_W'(CAP) && req_cell_value == CELL_PORTAL
          && pcount_ff < PCNT_W'(MAX_PORTALS))
         portal_mem[pcount_ff[PA_W-1:0]] <= load_idx_ff[IDX_W-1:0];
      portal_rd_ff <= portal_mem[pidx_ff[PA_W-1:0]];
   end

   // control and datapath registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rows_cfg_ff  <= CFG_W'(1);
         cols_cfg_ff  <= CFG_W'(1);
         load_idx_ff  <= '0;
         pcount_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         lvl_end_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_ROWS) rows_cfg_ff <= csr_wdata;
            else if (csr_index == CSR_GRID_COLS) cols_cfg_ff <= csr_wdata;
         end
         // new result replaces a taken one in the same cycle
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_LOAD: if (load_acc) begin
               if (load_idx_ff < CNT_W'(CAP)) begin
                  load_idx_ff <= load_idx_ff + 1'b1;
                  if (req_cell_value == CELL_PORTAL) begin
                     if (pcount_ff < PCNT_W'(MAX_PORTALS)) pcount_ff <= pcount_ff + 1'b1;
                     else ovf_ff <= 1'b1;
                  end
               end
            end
            S_INIT: begin
               head_ff  <= '0;
               tail_ff  <= CNT_W'(1);
            end
            S_LEVEL: lvl_end_ff <= tail_ff;
            S_POP: if (head_ff != lvl_end_ff) head_ff <= head_ff + 1'b1;
            S_DONE: if (rsp_free) begin
               load_idx_ff  <= '0;
               pcount_ff    <= '0;
               ovf_ff       <= 1'b0;
            end
            default: ;
         endcase
         if (push_en) tail_ff <= tail_ff + 1'b1;
      end

      // payload registers
      case (state_ff)
         S_LOAD: if (load_acc && req_last_cell) begin
            rows_ff   <= rows_cl;
            cols_ff   <= cols_cl;
            total_ff  <= TOT_W'(rows_cl) * TOT_W'(cols_cl);
            target_ff <= IDX_W'(TOT_W'(rows_cl) * TOT_W'(cols_cl) - 1'b1);
            clr_ff    <= '0;
         end
         S_CLEAR: clr_ff <= clr_ff + 1'b1;
         S_INIT: begin
            level_ff <= '0;
            found_ff <= 1'b0;
         end
         S_POP: if (head_ff == lvl_end_ff) level_ff <= level_ff + 1'b1;
         S_POPW: begin
            cur_ff <= q_rd_ff;
            if (q_rd_ff == target_ff) found_ff <= 1'b1;
         end
         S_DIV: if (div_done) begin
            r_ff <= div_quot[DIM_W-1:0];
            c_ff <= div_rem;
            k_ff <= DIR_DOWN;
         end
         S_NB: begin
            ni_ff <= ni;
            if (!nb_ok) k_ff <= k_ff + 1'b1;
         end
         S_NBW: begin
            pidx_ff <= '0;
            if (!(cell_rd_ff == CELL_PORTAL && !vis_rd_ff)) k_ff <= k_ff + 1'b1;
         end
         S_PIDX: begin
            pi_ff <= portal_rd_ff;
            if (TOT_W'(portal_rd_ff) >= total_ff) pidx_ff <= pidx_ff + 1'b1;
         end
         S_PVIS:   pidx_ff <= pidx_ff + 1'b1;
         S_PSELFW: k_ff <= k_ff + 1'b1;
         S_DONE: if (rsp_free) begin
            rsp_reach_ff <= found_ff;
            rsp_dist_ff  <= found_ff ? level_ff : '0;
            rsp_ovf_ff   <= ovf_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reachable       = rsp_reach_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_portal_overflow = rsp_ovf_ff;

   // queue pointers stay ordered
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");

   // a result only appears when a search completes
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result without finished search");

   // dequeue never runs past the current level
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (head_ff <= lvl_end_ff))
      else $error("level boundary overrun");

   // loads only happen while idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> req_stall) else $error("input taken mid search");

endmodule
